@@ hdl/gsme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsme_pkg
// shared types and constants of the graph segmentation merge engine
// ----------------------------------------------------------------------------
package gsme_pkg;

  localparam int unsigned NodeW  = 16;
  localparam int unsigned Nodes  = 1 << NodeW;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned ThrW   = 20;
  localparam int unsigned KW     = 19;
  localparam int unsigned WeightW = 16;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CfgW   = 19;

  localparam logic [ThrW-1:0] ThrMax = {ThrW{1'b1}};

  // function codes
  localparam logic [FuncW-1:0] FUNC_THR_MERGE   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_SMALL_MERGE = 2'd1;

  // register indexes
  localparam logic CFG_K_SCALED = 1'b0;
  localparam logic CFG_SMALL_LIM = 1'b1;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [SizeW-1:0] size_t;

  // one store entry
  typedef struct packed {
    node_t           parent;
    size_t           set_size;
    logic [ThrW-1:0] thr;
    logic            thr_written;
  } entry_t;

endpackage

@@ hdl/gsme_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsme_div
// restoring divider, one quotient bit per cycle, for k over region size
// ----------------------------------------------------------------------------
module gsme_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [gsme_pkg::KW-1:0] dividend_i,
  input  gsme_pkg::size_t         divisor_i,
  output logic                    done_o,
  output logic [gsme_pkg::KW-1:0] quot_o
);
  import gsme_pkg::*;

  localparam int unsigned CntW = $clog2(KW);
  localparam logic [CntW-1:0] LastCnt = CntW'(KW - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [KW-1:0]   dq_q, dq_d;
  size_t           rem_q, rem_d;
  size_t           dsr_q, dsr_d;
  logic            done_q, done_d;
  logic [SizeW:0]  rem_sh;

  assign rem_sh = {rem_q, dq_q[KW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = SizeW'(rem_sh - {1'b0, dsr_q});
        dq_d  = {dq_q[KW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[SizeW-1:0];
        dq_d  = {dq_q[KW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

@@ hdl/graph_segmentation_merge_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_segmentation_merge_engine_unit
// union-find merge engine for graph based segmentation
// ----------------------------------------------------------------------------
// One item at a time. Parent, region size and threshold of every node live in
// one single-port synchronous memory (one access per cycle, read data in the
// cycle after the address). An item walks from node a to its root, points a
// straight at that root, does the same for node b and then decides; a joining
// small-region merge adds a write back of the lower root, and a joining
// threshold merge first runs the bit-serial k / size divider and then writes
// back. The result is then registered and the engine is ready for the next
// beat. After reset the memory is swept to identity parents, size one and
// unwritten thresholds; during the sweep no beat is taken on the input
// (register writes work as ever). A finished result sits in an output
// register, so the next beat is taken while it waits.
module graph_segmentation_merge_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gsme_pkg::CfgW-1:0]    cfg_wdata_i,
  // edge / query input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gsme_pkg::FuncW-1:0]   func_i,
  input  logic [gsme_pkg::WeightW-1:0] weight_i,
  input  gsme_pkg::node_t              node_a_i,
  input  gsme_pkg::node_t              node_b_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         merged_o,
  output gsme_pkg::node_t              root_a_o,
  output gsme_pkg::node_t              root_b_o,
  output gsme_pkg::size_t              size_a_o,
  output gsme_pkg::size_t              size_b_o
);
  import gsme_pkg::*;

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FIND_A = 4'd2;
  localparam logic [3:0] S_CMP_A  = 4'd3;
  localparam logic [3:0] S_RD_B   = 4'd4;
  localparam logic [3:0] S_FIND_B = 4'd5;
  localparam logic [3:0] S_CMP_B  = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_WR_LO  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // configuration registers
  logic [KW-1:0] k_q;
  size_t         small_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(14080);
      small_lim_q <= SizeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_K_SCALED:  k_q         <= cfg_wdata_i[KW-1:0];
        CFG_SMALL_LIM: small_lim_q <= cfg_wdata_i[SizeW-1:0];
        default:       ;
      endcase
    end
  end

  // node store
  entry_t mem [Nodes];
  entry_t rdata_q;
  logic   mem_we;
  node_t  mem_addr;
  entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // control and item registers
  logic [3:0]           state_q, state_d;
  node_t                sweep_q, sweep_d;
  logic                 first_q, first_d;
  node_t                cur_q, cur_d;
  logic [FuncW-1:0]     func_q, func_d;
  logic [WeightW-1:0]   weight_q, weight_d;
  node_t                a_q, a_d, b_q, b_d;
  node_t                ra_q, ra_d, rb_q, rb_d;
  entry_t               start_q, start_d;   // entry of the node a walk begins at
  entry_t               ea_q, ea_d, eb_q, eb_d;  // root entries
  logic                 merged_q, merged_d;
  size_t                sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_merged_q, out_merged_d;
  node_t                out_ra_q, out_ra_d, out_rb_q, out_rb_d;
  size_t                out_sa_q, out_sa_d, out_sb_q, out_sb_d;

  // merge decision
  logic [ThrW-1:0] ta, tb, tmin;
  logic            join_thr, join_small, do_join, a_is_lo;
  node_t           lo, hi;
  entry_t          e_lo, e_hi;
  logic            div_start, div_done;
  logic [KW-1:0]   quot;
  logic [ThrW:0]   thr_sum;
  logic [ThrW-1:0] thr_new;

  assign ta   = ea_q.thr_written ? ea_q.thr : ThrW'(k_q);
  assign tb   = eb_q.thr_written ? eb_q.thr : ThrW'(k_q);
  assign tmin = (ta < tb) ? ta : tb;
  assign join_thr   = (func_q == FUNC_THR_MERGE) && (ThrW'(weight_q) <= tmin);
  assign join_small = (func_q == FUNC_SMALL_MERGE) &&
                      ((ea_q.set_size <= small_lim_q) || (eb_q.set_size <= small_lim_q));
  assign do_join = (ra_q != rb_q) && (join_thr || join_small);
  assign a_is_lo = ra_q < rb_q;
  assign lo      = a_is_lo ? ra_q : rb_q;
  assign hi      = a_is_lo ? rb_q : ra_q;
  assign e_lo    = a_is_lo ? ea_q : eb_q;
  assign e_hi    = a_is_lo ? eb_q : ea_q;

  assign thr_sum = (ThrW+1)'(weight_q) + (ThrW+1)'(quot);
  assign thr_new = (thr_sum > {1'b0, ThrMax}) ? ThrMax : thr_sum[ThrW-1:0];

  gsme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (k_q),
    .divisor_i  (sum_d),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    first_d      = first_q;
    cur_d        = cur_q;
    func_d       = func_q;
    weight_d     = weight_q;
    a_d          = a_q;
    b_d          = b_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    start_d      = start_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    merged_d     = merged_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_merged_d = out_merged_q;
    out_ra_d     = out_ra_q;
    out_rb_d     = out_rb_q;
    out_sa_d     = out_sa_q;
    out_sb_d     = out_sb_q;
    mem_we       = 1'b0;
    mem_addr     = cur_q;
    mem_wdata    = start_q;
    div_start    = 1'b0;

    unique case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = '{parent: sweep_q, set_size: SizeW'(1), thr: '0, thr_written: 1'b0};
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == node_t'(Nodes - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_addr = node_a_i;
        if (in_valid_i) begin
          func_d   = func_i;
          weight_d = weight_i;
          a_d      = node_a_i;
          b_d      = node_b_i;
          cur_d    = node_a_i;
          first_d  = 1'b1;
          state_d  = S_FIND_A;
        end
      end
      S_FIND_A, S_FIND_B: begin
        first_d = 1'b0;
        if (first_q) begin
          start_d = rdata_q;
        end
        if (rdata_q.parent == cur_q) begin
          if (state_q == S_FIND_A) begin
            ra_d    = cur_q;
            ea_d    = rdata_q;
            state_d = S_CMP_A;
          end else begin
            rb_d    = cur_q;
            eb_d    = rdata_q;
            state_d = S_CMP_B;
          end
        end else begin
          cur_d    = rdata_q.parent;
          mem_addr = rdata_q.parent;
        end
      end
      S_CMP_A: begin
        // point node a straight at its root
        mem_we    = 1'b1;
        mem_addr  = a_q;
        mem_wdata = start_q;
        mem_wdata.parent = ra_q;
        state_d   = S_RD_B;
      end
      S_RD_B: begin
        mem_addr = b_q;
        cur_d    = b_q;
        first_d  = 1'b1;
        state_d  = S_FIND_B;
      end
      S_CMP_B: begin
        mem_we    = 1'b1;
        mem_addr  = b_q;
        mem_wdata = start_q;
        mem_wdata.parent = rb_q;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        merged_d = do_join;
        sum_d    = SizeW'(ea_q.set_size + eb_q.set_size);
        if (do_join) begin
          // hang the higher root under the lower one
          mem_we    = 1'b1;
          mem_addr  = hi;
          mem_wdata = e_hi;
          mem_wdata.parent = lo;
          if (join_thr) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            state_d = S_WR_LO;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_WR_LO;
        end
      end
      S_WR_LO: begin
        mem_we    = 1'b1;
        mem_addr  = lo;
        mem_wdata = e_lo;
        mem_wdata.set_size = sum_q;
        if (func_q == FUNC_THR_MERGE) begin
          mem_wdata.thr         = thr_new;
          mem_wdata.thr_written = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_merged_d = merged_q;
          out_ra_d     = merged_q ? lo : ra_q;
          out_rb_d     = merged_q ? lo : rb_q;
          out_sa_d     = merged_q ? sum_q : ea_q.set_size;
          out_sb_d     = merged_q ? sum_q : eb_q.set_size;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    func_q       <= func_d;
    weight_q     <= weight_d;
    a_q          <= a_d;
    b_q          <= b_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    start_q      <= start_d;
    ea_q         <= ea_d;
    eb_q         <= eb_d;
    merged_q     <= merged_d;
    sum_q        <= sum_d;
    out_merged_q <= out_merged_d;
    out_ra_q     <= out_ra_d;
    out_rb_q     <= out_rb_d;
    out_sa_q     <= out_sa_d;
    out_sb_q     <= out_sb_d;
  end

  assign out_valid_o = out_valid_q;
  assign merged_o    = out_merged_q;
  assign root_a_o    = out_ra_q;
  assign root_b_o    = out_rb_q;
  assign size_a_o    = out_sa_q;
  assign size_b_o    = out_sb_q;

endmodule

@@ hdl/gsme_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsme_checker
// port level checks of the merge engine
// ----------------------------------------------------------------------------
module gsme_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            merged_o,
  input gsme_pkg::node_t root_a_o,
  input gsme_pkg::node_t root_b_o,
  input gsme_pkg::size_t size_a_o,
  input gsme_pkg::size_t size_b_o
);
  import gsme_pkg::*;

  // stalled result beat holds valid, root a and size a
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_a_o) && $stable(size_a_o))
    else $error("result beat changed while stalled");

  // a join leaves both nodes in one region
  a_merged_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> root_a_o == root_b_o)
    else $error("merged beat with two roots");

  // one region reports one size
  a_same_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_a_o == root_b_o |-> size_a_o == size_b_o)
    else $error("one root with two sizes");

  // a joined region holds at least two nodes
  a_merged_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> size_a_o > SizeW'(1))
    else $error("merged region too small");

endmodule

bind graph_segmentation_merge_engine_unit gsme_checker u_gsme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .merged_o    (merged_o),
  .root_a_o    (root_a_o),
  .root_b_o    (root_b_o),
  .size_a_o    (size_a_o),
  .size_b_o    (size_b_o)
);

@@ sim/graph_segmentation_merge_engine_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_segmentation_merge_engine_unit_test
// self-checking bench for the union-find merge engine
// ----------------------------------------------------------------------------
// An initial block fills a queue of edge and query beats, phase by phase,
// and writes k and the small-region limit only while the engine is idle. A
// clocked driver sends the queue in bursts with random gaps, and a clocked
// monitor compares every result beat with a prediction from a local copy of
// the union-find store, computed when the input beat is accepted.
module graph_segmentation_merge_engine_unit_test;
  import gsme_pkg::*;

  localparam logic [FuncW-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned      CycleLimit  = 1500000;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [WeightW-1:0] weight;
    node_t              a;
    node_t              b;
  } edge_beat_t;

  typedef struct packed {
    logic  merged;
    node_t root_a;
    node_t root_b;
    size_t size_a;
    size_t size_b;
  } region_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_K_SCALED;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FuncW-1:0] func = '0;
  logic [WeightW-1:0] weight = '0;
  node_t node_a = '0;
  node_t node_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic merged;
  node_t root_a, root_b;
  size_t size_a, size_b;

  graph_segmentation_merge_engine_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .weight_i(weight), .node_a_i(node_a), .node_b_i(node_b),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .merged_o(merged), .root_a_o(root_a), .root_b_o(root_b),
    .size_a_o(size_a), .size_b_o(size_b)
  );

  always #5 clk = ~clk;

  // local copy of the union-find store
  node_t           uf_parent [Nodes];
  size_t           uf_size   [Nodes];
  logic [ThrW-1:0] uf_thr    [Nodes];
  bit              uf_thr_set[Nodes];
  logic [KW-1:0]   k_val   = 19'd14080;
  size_t           min_val = 17'd1;

  edge_beat_t pending_edges[$];
  region_t    expected_regions[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          stim_done = 1'b0;

  // walk to the root, then point only the start node at it
  function automatic node_t find_root(node_t x);
    node_t y;
    y = x;
    while (uf_parent[y] != y) y = uf_parent[y];
    uf_parent[x] = y;
    return y;
  endfunction

  function automatic logic [ThrW-1:0] thr_of(node_t r);
    return uf_thr_set[r] ? uf_thr[r] : ThrW'(k_val);
  endfunction

  function automatic node_t join_roots(node_t ra, node_t rb);
    node_t lo, hi;
    lo = (ra < rb) ? ra : rb;
    hi = (ra < rb) ? rb : ra;
    uf_parent[hi] = lo;
    uf_size[lo] = uf_size[lo] + uf_size[hi];
    return lo;
  endfunction

  function automatic region_t predict_region(edge_beat_t e);
    region_t r;
    node_t ra, rb, j;
    logic [ThrW-1:0] ta, tb, tmin;
    logic [ThrW:0] t;
    r = '0;
    ra = find_root(e.a);
    rb = find_root(e.b);
    if (ra != rb) begin
      if (e.func == FUNC_THR_MERGE) begin
        ta = thr_of(ra);
        tb = thr_of(rb);
        tmin = (ta < tb) ? ta : tb;
        if (ThrW'(e.weight) <= tmin) begin
          j = join_roots(ra, rb);
          t = (ThrW+1)'(e.weight) + (ThrW+1)'(k_val / uf_size[j]);
          uf_thr[j] = (t > (ThrW+1)'(ThrMax)) ? ThrMax : t[ThrW-1:0];
          uf_thr_set[j] = 1'b1;
          ra = j;
          rb = j;
          r.merged = 1'b1;
        end
      end else if (e.func == FUNC_SMALL_MERGE) begin
        if (uf_size[ra] <= min_val || uf_size[rb] <= min_val) begin
          j = join_roots(ra, rb);
          ra = j;
          rb = j;
          r.merged = 1'b1;
        end
      end
    end
    r.root_a = ra;
    r.root_b = rb;
    r.size_a = uf_size[ra];
    r.size_b = uf_size[rb];
    return r;
  endfunction

  // driver: bursts of beats with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          in_taken = 1'b0;
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // hold the beat
    end else if (pending_edges.size() != 0 && gap_left == 0 && rst_n) begin
      edge_beat_t e;
      e = pending_edges.pop_front();
      in_valid <= 1'b1;
      func <= e.func;
      weight <= e.weight;
      node_a <= e.a;
      node_b <= e.b;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
      if (gap_left != 0) gap_left--;
    end
    // receiver stalls on its own pattern, with long clean stretches
    out_ready <= ((cycles / 500) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // input acceptance drives the prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expected_regions.push_back(predict_region('{func, weight, node_a, node_b}));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_regions.size() == 0) begin
        $error("result beat with no expectation");
        mismatches++;
      end else begin
        region_t x;
        x = expected_regions.pop_front();
        if (merged !== x.merged) begin
          $error("merged expected %0d actual %0d", x.merged, merged); mismatches++;
        end
        if (root_a !== x.root_a) begin
          $error("root_a expected %0d actual %0d", x.root_a, root_a); mismatches++;
        end
        if (root_b !== x.root_b) begin
          $error("root_b expected %0d actual %0d", x.root_b, root_b); mismatches++;
        end
        if (size_a !== x.size_a) begin
          $error("size_a expected %0d actual %0d", x.size_a, size_a); mismatches++;
        end
        if (size_b !== x.size_b) begin
          $error("size_b expected %0d actual %0d", x.size_b, size_b); mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic edge_beat_t mk(logic [FuncW-1:0] f, int unsigned w,
                                    int unsigned a, int unsigned b);
    edge_beat_t e;
    e.func = f;
    e.weight = WeightW'(w);
    e.a = node_t'(a);
    e.b = node_t'(b);
    return e;
  endfunction

  // wait until the engine is idle, then write one register
  task automatic write_reg(logic idx, int unsigned val);
    while (pending_edges.size() != 0 || in_valid || expected_regions.size() != 0)
      @(posedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CfgW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_K_SCALED) k_val = KW'(val);
    else min_val = SizeW'(val);
  endtask

  // one phase of random edges over a small node window, mostly ascending weights
  task automatic random_phase(int unsigned count, int unsigned span,
                              int unsigned base);
    int unsigned w;
    w = 0;
    for (int unsigned i = 0; i < count; i++) begin
      int unsigned sel, a, b;
      logic [FuncW-1:0] f;
      sel = $urandom_range(0, 9);
      f = (sel < 6) ? FUNC_THR_MERGE : (sel < 8) ? FUNC_SMALL_MERGE
        : (sel == 8) ? FUNC_QUERY : FUNC_UNUSED;
      w = w + $urandom_range(0, 300);
      if (w > 65535 || $urandom_range(0, 40) == 0) w = $urandom_range(0, 65535);
      a = base + $urandom_range(0, span - 1);
      b = base + $urandom_range(0, span - 1);
      if ($urandom_range(0, 30) == 0) a = $urandom_range(0, 65535);
      pending_edges.push_back(mk(f, w, a, b));
    end
  endtask

  initial begin
    for (int i = 0; i < Nodes; i++) begin
      uf_parent[i] = node_t'(i);
      uf_size[i] = SizeW'(1);
      uf_thr[i] = '0;
      uf_thr_set[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every function, unused code, same region
    pending_edges.push_back(mk(FUNC_QUERY, 0, 0, 65535));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 0, 0, 1));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 65535, 2, 3));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 100, 1, 0));
    pending_edges.push_back(mk(FUNC_SMALL_MERGE, 0, 65535, 65534));
    pending_edges.push_back(mk(FUNC_SMALL_MERGE, 65535, 65534, 0));
    pending_edges.push_back(mk(FUNC_UNUSED, 21845, 43690, 65535));
    pending_edges.push_back(mk(FUNC_QUERY, 43690, 1, 65535));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 5000, 4, 4));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 14080, 10, 11));
    pending_edges.push_back(mk(FUNC_THR_MERGE, 14081, 12, 11));
    random_phase(300, 24, 100);

    write_reg(CFG_K_SCALED, 524287);
    write_reg(CFG_SMALL_LIM, 0);
    pending_edges.push_back(mk(FUNC_THR_MERGE, 65535, 65533, 65532));
    pending_edges.push_back(mk(FUNC_SMALL_MERGE, 0, 200, 201));
    random_phase(300, 40, 1000);

    write_reg(CFG_K_SCALED, 0);
    write_reg(CFG_SMALL_LIM, 65536);
    random_phase(300, 32, 3000);

    write_reg(CFG_SMALL_LIM, 131071);
    write_reg(CFG_K_SCALED, $urandom_range(1, 524287));
    random_phase(300, 64, 20000);

    write_reg(CFG_SMALL_LIM, $urandom_range(2, 8));
    write_reg(CFG_K_SCALED, 14080);
    random_phase(330, 48, 40000);

    while (pending_edges.size() != 0 || in_valid || expected_regions.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_regions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gsme_pkg.sv
hdl/gsme_div.sv
hdl/graph_segmentation_merge_engine_unit.sv
hdl/gsme_checker.sv
sim/graph_segmentation_merge_engine_unit_test.sv
